@@ design/rk4_pkg.sv @@
// Shared constants, datapath command codes and tables for the RK4 stepper.
package rk4_pkg;

  // Fixed-point format and CORDIC length
  localparam int FRAC_BITS      = 24;
  localparam int COS_ITERATIONS = 24;

  // Angle scaling from Q.FRAC_BITS up to Q.30
  localparam int SH    = 30 - FRAC_BITS;
  // Angle register width: holds up to 2*pi << (SH+1)
  localparam int RW    = SH + 36;
  // CORDIC x/y width (Q.30 with headroom)
  localparam int CW    = 34;
  // Iteration index width
  localparam int IDX_W = 5;
  // Radix-4 digits needed for a 36-bit dividend
  localparam int DIV_STEPS = 18;

  // Q.30 angle constants
  localparam logic signed [RW-1:0] TWO_PI_Q30  = RW'(64'sd6746518852);
  localparam logic signed [RW-1:0] PI_Q30      = RW'(64'sd3373259426);
  localparam logic signed [RW-1:0] HALF_PI_Q30 = RW'(64'sd1686629713);
  localparam logic signed [CW-1:0] GAIN_Q30    = CW'(64'sd652032874);

  // Configuration register indexes
  localparam logic [1:0] CFG_STEP_SIZE = 2'd0;
  localparam logic [1:0] CFG_START_X   = 2'd1;
  localparam logic [1:0] CFG_START_Y   = 2'd2;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_INIT,
    OP_ARG,
    OP_MUL_YY,
    OP_MUL_TC,
    OP_MUL_HS,
    OP_RND,
    OP_ONEM,
    OP_RPRE,
    OP_RED,
    OP_FOLD1,
    OP_FOLD2,
    OP_CORD,
    OP_CRND,
    OP_SLOPE,
    OP_ACC,
    OP_DPRE,
    OP_DIV,
    OP_FIN
  } op_e;

  // Command from controller to datapath
  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic [1:0]       kidx;
    logic             restart;
  } cmd_t;

  // arctan(2^-i) in Q.30
  function automatic logic signed [31:0] atan_q30(input logic [IDX_W-1:0] i);
    logic signed [31:0] v;
    unique case (i)
      5'd0:  v = 32'sd843314857;
      5'd1:  v = 32'sd497837829;
      5'd2:  v = 32'sd263043837;
      5'd3:  v = 32'sd133525159;
      5'd4:  v = 32'sd67021687;
      5'd5:  v = 32'sd33543516;
      5'd6:  v = 32'sd16775851;
      5'd7:  v = 32'sd8388437;
      5'd8:  v = 32'sd4194283;
      5'd9:  v = 32'sd2097149;
      5'd10: v = 32'sd1048576;
      5'd11: v = 32'sd524288;
      5'd12: v = 32'sd262144;
      5'd13: v = 32'sd131072;
      5'd14: v = 32'sd65536;
      5'd15: v = 32'sd32768;
      5'd16: v = 32'sd16384;
      5'd17: v = 32'sd8192;
      5'd18: v = 32'sd4096;
      5'd19: v = 32'sd2048;
      5'd20: v = 32'sd1024;
      5'd21: v = 32'sd512;
      5'd22: v = 32'sd256;
      5'd23: v = 32'sd128;
      5'd24: v = 32'sd64;
      5'd25: v = 32'sd32;
      5'd26: v = 32'sd16;
      5'd27: v = 32'sd8;
      5'd28: v = 32'sd4;
      5'd29: v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ design/rk4_ctrl.sv @@
// Sequencer for the RK4 stepper: handshakes and datapath command stream.
module rk4_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          restart_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rk4_pkg::cmd_t cmd_o
);
  import rk4_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_INIT  = 5'd1;
  localparam logic [4:0] ST_ARG   = 5'd2;
  localparam logic [4:0] ST_MULYY = 5'd3;
  localparam logic [4:0] ST_RND1  = 5'd4;
  localparam logic [4:0] ST_ONEM  = 5'd5;
  localparam logic [4:0] ST_RPRE  = 5'd6;
  localparam logic [4:0] ST_RED   = 5'd7;
  localparam logic [4:0] ST_FOLD1 = 5'd8;
  localparam logic [4:0] ST_FOLD2 = 5'd9;
  localparam logic [4:0] ST_CORD  = 5'd10;
  localparam logic [4:0] ST_CRND  = 5'd11;
  localparam logic [4:0] ST_MULTC = 5'd12;
  localparam logic [4:0] ST_RND2  = 5'd13;
  localparam logic [4:0] ST_SLOPE = 5'd14;
  localparam logic [4:0] ST_MULHS = 5'd15;
  localparam logic [4:0] ST_RND3  = 5'd16;
  localparam logic [4:0] ST_ACC   = 5'd17;
  localparam logic [4:0] ST_DPRE  = 5'd18;
  localparam logic [4:0] ST_DIV   = 5'd19;
  localparam logic [4:0] ST_FIN   = 5'd20;

  localparam logic [IDX_W-1:0] RED_LAST  = IDX_W'(SH);
  localparam logic [IDX_W-1:0] CORD_LAST = IDX_W'(COS_ITERATIONS - 1);
  localparam logic [IDX_W-1:0] DIV_LAST  = IDX_W'(DIV_STEPS - 1);

  logic [4:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [1:0]       kidx_q, kidx_d;
  logic             restart_q, restart_d;
  logic             out_valid_q, out_valid_d;
  logic             fin_ok;
  op_e              op;

  assign fin_ok = !out_valid_q || out_ready_i;

  // Next state and command
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    kidx_d      = kidx_q;
    restart_d   = restart_q;
    out_valid_d = out_valid_q && !out_ready_i;
    op          = OP_NOP;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          restart_d = restart_i;
          kidx_d    = 2'd0;
          state_d   = ST_INIT;
        end
      end
      ST_INIT:  begin op = OP_INIT;   state_d = ST_ARG; end
      ST_ARG:   begin op = OP_ARG;    state_d = ST_MULYY; end
      ST_MULYY: begin op = OP_MUL_YY; state_d = ST_RND1; end
      ST_RND1:  begin op = OP_RND;    state_d = ST_ONEM; end
      ST_ONEM:  begin op = OP_ONEM;   state_d = ST_RPRE; idx_d = '0; end
      ST_RPRE:  begin op = OP_RPRE;   state_d = ST_RED; end
      ST_RED: begin
        op = OP_RED;
        if (idx_q == RED_LAST) begin
          idx_d   = '0;
          state_d = ST_FOLD1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FOLD1: begin op = OP_FOLD1; state_d = ST_FOLD2; end
      ST_FOLD2: begin op = OP_FOLD2; state_d = ST_CORD; idx_d = '0; end
      ST_CORD: begin
        op = OP_CORD;
        if (idx_q == CORD_LAST) begin
          idx_d   = '0;
          state_d = ST_CRND;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_CRND:  begin op = OP_CRND;   state_d = ST_MULTC; end
      ST_MULTC: begin op = OP_MUL_TC; state_d = ST_RND2; end
      ST_RND2:  begin op = OP_RND;    state_d = ST_SLOPE; end
      ST_SLOPE: begin op = OP_SLOPE;  state_d = ST_MULHS; end
      ST_MULHS: begin op = OP_MUL_HS; state_d = ST_RND3; end
      ST_RND3:  begin op = OP_RND;    state_d = ST_ACC; end
      ST_ACC: begin
        op = OP_ACC;
        if (kidx_q == 2'd3) begin
          state_d = ST_DPRE;
        end else begin
          kidx_d  = kidx_q + 1'b1;
          state_d = ST_ARG;
        end
      end
      ST_DPRE: begin op = OP_DPRE; state_d = ST_DIV; idx_d = '0; end
      ST_DIV: begin
        op = OP_DIV;
        if (idx_q == DIV_LAST) begin
          idx_d   = '0;
          state_d = ST_FIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (fin_ok) begin
          op          = OP_FIN;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      kidx_q      <= '0;
      restart_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      kidx_q      <= kidx_d;
      restart_q   <= restart_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.op      = op;
  assign cmd_o.idx     = idx_q;
  assign cmd_o.kidx    = kidx_q;
  assign cmd_o.restart = restart_q;

`ifndef NO_ASSERTIONS
  // An accepted request makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("not busy after accepting a request");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && out_valid_q && !out_ready_i |=> (state_q == ST_FIN))
    else $error("finish step taken while result pending");

  // CORDIC index stays within its iteration count
  a_cord_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CORD) |-> (idx_q <= CORD_LAST))
    else $error("CORDIC index out of range");
`endif

endmodule

@@ design/rk4_dp.sv @@
// Datapath of the RK4 stepper: state, multiplier, CORDIC, divider, output registers.
module rk4_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rk4_pkg::cmd_t      cmd_i,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic signed [31:0] x_value_o,
  output logic signed [31:0] y_value_o,
  output logic               saturated_o
);
  import rk4_pkg::*;

  localparam logic signed [63:0] ONE_Q     = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF_LSB  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] I32_MAX   = 64'sd2147483647;
  localparam logic signed [63:0] I32_MIN   = -64'sd2147483648;
  localparam logic signed [CW-1:0] COS_RND =
    CW'(SH > 0) <<< ((SH > 0) ? SH - 1 : 0);
  localparam logic signed [36:0] DIV_BIAS  = 37'sd25769803779; // 6*2^32 + 3
  localparam logic signed [36:0] Q_BIAS    = 37'sd4294967296;

  // Clip to 32 bits signed; bit 32 is the clip flag
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > I32_MAX)      r = {1'b1, 32'h7fffffff};
    else if (v < I32_MIN) r = {1'b1, 32'h80000000};
    else                  r = {1'b0, v[31:0]};
    return r;
  endfunction

  // Configuration and step state
  logic [30:0]        h_q;
  logic signed [31:0] sx_q, sy_q, x_q, y_q;
  // Working registers
  logic signed [31:0] xm_q, xe_q, xs_q, ys_q, k_q, mres_q, onem_q, cos_q, slope_q;
  logic signed [63:0] p_q;
  logic signed [34:0] acc_q;
  logic signed [RW-1:0] r_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic               neg_q, clip_q;
  logic [35:0]        div_q;
  logic [2:0]         rem_q;
  logic signed [31:0] xo_q, yo_q;
  logic               so_q;

  // Combinational results
  logic signed [31:0] h32, xb, yb, kadd, ma, mb;
  logic [32:0]        s_xm, s_xe, s_ys, s_rnd, s_onem, s_slope, s_y;
  logic signed [63:0] prod, pr;
  logic signed [34:0] kw;
  logic signed [RW-1:0] rx, r_pre, m_red, r_red, r_f1, r_f2, at;
  logic               neg_f2;
  logic signed [CW-1:0] dx, dy, t_c, t_n;
  logic [36:0]        u_full;
  logic [4:0]         t5;
  logic [1:0]         dig;
  logic [2:0]         rem_n;
  logic signed [36:0] qv;

  always_comb begin
    h32 = $signed({1'b0, h_q});
    xb  = cmd_i.restart ? sx_q : x_q;
    yb  = cmd_i.restart ? sy_q : y_q;

    // Midpoint and end x
    s_xm = sat32(64'(xb) + 64'(h32 >>> 1));
    s_xe = sat32(64'(xb) + 64'(h32));

    // Slope argument y
    kadd = (cmd_i.kidx == 2'd3) ? k_q : (k_q >>> 1);
    s_ys = sat32(64'(y_q) + 64'(kadd));

    // Shared multiplier operands
    unique case (cmd_i.op)
      OP_MUL_YY: begin ma = ys_q;   mb = ys_q; end
      OP_MUL_TC: begin ma = onem_q; mb = cos_q; end
      default:   begin ma = h32;    mb = slope_q; end
    endcase
    prod = 64'(ma) * 64'(mb);

    // Product rounding
    pr    = (p_q + HALF_LSB) >>> FRAC_BITS;
    s_rnd = sat32(pr);

    s_onem  = sat32(ONE_Q - 64'(mres_q));
    s_slope = sat32(64'(mres_q) + 64'(ys_q >>> 1));

    // Weighted accumulate: k2 and k3 count twice
    kw = (cmd_i.kidx == 2'd1 || cmd_i.kidx == 2'd2) ? (35'(mres_q) <<< 1) : 35'(mres_q);

    // Angle reduction modulo 2*pi
    rx    = RW'(xs_q) <<< SH;
    r_pre = (rx < 0) ? rx + (TWO_PI_Q30 <<< SH) : rx;
    m_red = TWO_PI_Q30 <<< (SH - int'(cmd_i.idx));
    r_red = (r_q >= m_red) ? r_q - m_red : r_q;
    r_f1  = (r_q > PI_Q30) ? r_q - TWO_PI_Q30 : r_q;
    if (r_q > HALF_PI_Q30) begin
      r_f2 = PI_Q30 - r_q;  neg_f2 = 1'b1;
    end else if (r_q < -HALF_PI_Q30) begin
      r_f2 = -PI_Q30 - r_q; neg_f2 = 1'b1;
    end else begin
      r_f2 = r_q;           neg_f2 = 1'b0;
    end

    // CORDIC rotation step
    dx = cy_q >>> cmd_i.idx;
    dy = cx_q >>> cmd_i.idx;
    at = RW'(atan_q30(cmd_i.idx));

    // Cosine rounding to Q.FRAC_BITS
    t_c = (cx_q + COS_RND) >>> SH;
    t_n = neg_q ? -t_c : t_c;

    // Divide by 6: biased dividend, radix-4 digits
    u_full = 37'(acc_q) + DIV_BIAS;
    t5     = {rem_q, div_q[35:34]};
    if (t5 >= 5'd18)      dig = 2'd3;
    else if (t5 >= 5'd12) dig = 2'd2;
    else if (t5 >= 5'd6)  dig = 2'd1;
    else                  dig = 2'd0;
    rem_n = 3'(t5 - 5'd6 * {3'd0, dig});

    qv  = $signed({1'b0, div_q}) - Q_BIAS;
    s_y = sat32(64'(y_q) + 64'(qv));
  end

  // Configuration and step state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q    <= 31'd1677722;
      sx_q   <= '0;
      sy_q   <= '0;
      x_q    <= '0;
      y_q    <= '0;
      clip_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_STEP_SIZE: h_q  <= cfg_data_i[30:0];
          CFG_START_X:   sx_q <= $signed(cfg_data_i);
          CFG_START_Y:   sy_q <= $signed(cfg_data_i);
          default: ;
        endcase
      end
      unique case (cmd_i.op)
        OP_INIT: begin
          x_q    <= xb;
          y_q    <= yb;
          clip_q <= s_xm[32] | s_xe[32];
        end
        OP_ARG:   clip_q <= clip_q | s_ys[32];
        OP_RND:   clip_q <= clip_q | s_rnd[32];
        OP_ONEM:  clip_q <= clip_q | s_onem[32];
        OP_SLOPE: clip_q <= clip_q | s_slope[32];
        OP_FIN: begin
          x_q    <= xe_q;
          y_q    <= s_y[31:0];
          clip_q <= clip_q | s_y[32];
        end
        default: ;
      endcase
    end
  end

  // Working and output registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_INIT: begin
        xm_q  <= s_xm[31:0];
        xe_q  <= s_xe[31:0];
        acc_q <= '0;
        k_q   <= '0;
      end
      OP_ARG: begin
        xs_q <= (cmd_i.kidx == 2'd0) ? x_q : ((cmd_i.kidx == 2'd3) ? xe_q : xm_q);
        ys_q <= (cmd_i.kidx == 2'd0) ? y_q : s_ys[31:0];
      end
      OP_MUL_YY, OP_MUL_TC, OP_MUL_HS: p_q <= prod;
      OP_RND:   mres_q  <= s_rnd[31:0];
      OP_ONEM:  onem_q  <= s_onem[31:0];
      OP_RPRE:  r_q     <= r_pre;
      OP_RED:   r_q     <= r_red;
      OP_FOLD1: r_q     <= r_f1;
      OP_FOLD2: begin
        r_q   <= r_f2;
        neg_q <= neg_f2;
        cx_q  <= GAIN_Q30;
        cy_q  <= '0;
      end
      OP_CORD: begin
        if (r_q >= 0) begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          r_q  <= r_q - at;
        end else begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          r_q  <= r_q + at;
        end
      end
      OP_CRND:  cos_q   <= t_n[31:0];
      OP_SLOPE: slope_q <= s_slope[31:0];
      OP_ACC: begin
        k_q   <= mres_q;
        acc_q <= acc_q + kw;
      end
      OP_DPRE: begin
        div_q <= u_full[35:0];
        rem_q <= '0;
      end
      OP_DIV: begin
        div_q <= {div_q[33:0], dig};
        rem_q <= rem_n;
      end
      OP_FIN: begin
        xo_q <= xe_q;
        yo_q <= s_y[31:0];
        so_q <= clip_q | s_y[32];
      end
      default: ;
    endcase
  end

  assign x_value_o   = xo_q;
  assign y_value_o   = yo_q;
  assign saturated_o = so_q;

endmodule

@@ design/rk4_ode_stepper.sv @@
// Top level of the RK4 stepper for y' = (1 - y^2)cos(x) + y/2.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, restart_i): each request takes one
//   RK4 step from the kept point (x, y). restart_i = 1 first reloads x and y
//   from start_x and start_y.
//   Output channel (out_valid_o/out_ready_i): one result per request with x and
//   y after the step (signed Q8.24) and saturated_o when any value was clipped.
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): index 0
//   step_size, 1 start_x, 2 start_y; always ready; write only while idle.
// Sequencing:
//   Requests are taken one at a time. Each request runs four slope
//   evaluations, each a serial angle reduction, a one-iteration-per-cycle
//   CORDIC and three passes through the one multiplier, and then the
//   radix-4 divide by 6 at the end.
//   The result sits in an output register; a new request is taken while it
//   waits, and a finished step holds until that register is free.
// Reset: x = y = 0, step_size = 0.1, start values 0, no result pending.
module rk4_ode_stepper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] x_value_o,
  output logic signed [31:0] y_value_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import rk4_pkg::*;

  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  rk4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Arithmetic
  rk4_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .x_value_o   (x_value_o),
    .y_value_o   (y_value_o),
    .saturated_o (saturated_o)
  );

endmodule
